// ===== sv/pwarp_pkg.sv =====
// ---------------------------------------------------------------------------
// pwarp_pkg
// Shared types and constants of the polynomial image warp.
// ---------------------------------------------------------------------------
package pwarp_pkg;

    localparam int COEF_W   = 48;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam int SAMPLE_W = 32;

    typedef logic signed [COEF_W-1:0] t_coef;

    // register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_X_COL    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_ROW    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_CROSS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Y_COL    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_ROW    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_Y_CROSS  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 3'd7;

    // 1.0 in Q15.32
    localparam t_coef COEF_ONE = 48'sh0001_0000_0000;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // per-stage load enables of the mapping pipe
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

// ===== sv/polynomial_image_warp_top.sv =====
// ---------------------------------------------------------------------------
// polynomial_image_warp_top
// Ortho-correction resampler: bilinear source mapping, nearest-neighbour read.
// ---------------------------------------------------------------------------
// Read results pass stages S1 to S4 and show on m_axis from the S5 register.
// Throughput: one transfer per cycle unless m_axis stalls, reads and writes
// mixed freely; set by the five-stage pipe with one single-port store access.
// Reset (synchronous, i_rst_n low) clears all stage valid bits and loads the
// coefficients with the identity mapping; the source store is not cleared.
// ---------------------------------------------------------------------------
module polynomial_image_warp_top #(
    parameter int IMAGE_WIDTH  = 256,
    parameter int IMAGE_HEIGHT = 256,
    parameter int BANDS        = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pwarp_pkg::REG_IDX_W-1:0]     i_cfg_addr,
    input  logic [pwarp_pkg::COEF_W-1:0]        i_cfg_wdata,
    // command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] col, [15:8] row, [17:16] band, [49:18] sample_in, [55:50] zero
    input  logic [55:0]                         s_axis_tdata,
    // [0] cmd
    input  logic                                s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] sample_out
    output logic [31:0]                         m_axis_tdata,
    // [0] source_inside
    output logic                                m_axis_tuser
);
    import pwarp_pkg::*;

    // address fields of the source store: band, row, column
    localparam int CW   = (IMAGE_WIDTH  > 1) ? $clog2(IMAGE_WIDTH)  : 1;
    localparam int RW   = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
    localparam int BW   = (BANDS        > 1) ? $clog2(BANDS)        : 1;
    localparam int AW   = BW + RW + CW;
    localparam int DEPTH = 1 << AW;

    // coefficient registers
    t_coef r_coef [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[REG_X_COL] <= COEF_ONE;
            r_coef[REG_Y_ROW] <= COEF_ONE;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // Pipe: S1 products, S2 sums/cross product, S3 exact sum and inside test,
    // S4 store access, S5 output register. Each stage loads when it is empty
    // or its successor loads, so bubbles close up behind a stalled result.
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    t_stage_en en;

    assign rdy5 = !r5_v || m_axis_tready;
    assign rdy4 = !r4_v || rdy5;
    assign rdy3 = !r3_v || rdy4;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;
    assign en   = '{s1: rdy1, s2: rdy2, s3: rdy3};

    assign s_axis_tready = rdy1;

    // payload carried alongside the mapping
    logic                r1_cmd, r2_cmd, r3_cmd;
    logic [7:0]          r1_col, r2_col;
    logic [7:0]          r1_row, r2_row;
    logic [1:0]          r1_band, r2_band;
    logic [SAMPLE_W-1:0] r1_sample, r2_sample, r3_sample;
    logic                r3_wr_ok;
    logic                r3_band_ok;
    logic [AW-1:0]       r3_wr_addr;
    logic [BW-1:0]       r3_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= s_axis_tvalid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            // writes end in the store and leave no result behind
            if (rdy4) r4_v <= r3_v && (r3_cmd == CMD_READ);
            if (rdy5) r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_cmd    <= s_axis_tuser;
            r1_col    <= s_axis_tdata[7:0];
            r1_row    <= s_axis_tdata[15:8];
            r1_band   <= s_axis_tdata[17:16];
            r1_sample <= s_axis_tdata[49:18];
        end
        if (rdy2) begin
            r2_cmd    <= r1_cmd;
            r2_col    <= r1_col;
            r2_row    <= r1_row;
            r2_band   <= r1_band;
            r2_sample <= r1_sample;
        end
    end

    // write range check and address; band check serves reads as well
    logic [12:0] col_ext, row_ext;
    logic [8:0]  band_ext;
    logic        band_ok;

    assign col_ext  = {5'd0, r2_col};
    assign row_ext  = {5'd0, r2_row};
    assign band_ext = {7'd0, r2_band};
    assign band_ok  = band_ext < 9'(BANDS);

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_cmd     <= r2_cmd;
            r3_sample  <= r2_sample;
            r3_band    <= band_ext[BW-1:0];
            r3_band_ok <= band_ok;
            r3_wr_ok   <= band_ok && (col_ext < 13'(IMAGE_WIDTH)) &&
                          (row_ext < 13'(IMAGE_HEIGHT));
            r3_wr_addr <= {band_ext[BW-1:0], row_ext[RW-1:0], col_ext[CW-1:0]};
        end
    end

    // source position, valid at stage 3
    logic          x_inside, y_inside;
    logic [CW-1:0] sx;
    logic [RW-1:0] sy;

    pwarp_map #(.LIMIT(IMAGE_WIDTH), .CRD_W(CW)) u_map_x (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_col        (s_axis_tdata[7:0]),
        .i_row        (s_axis_tdata[15:8]),
        .i_coef_col   (r_coef[REG_X_COL]),
        .i_coef_row   (r_coef[REG_X_ROW]),
        .i_coef_cross (r_coef[REG_X_CROSS]),
        .i_coef_off   (r_coef[REG_X_OFFSET]),
        .o_inside     (x_inside),
        .o_coord      (sx)
    );

    pwarp_map #(.LIMIT(IMAGE_HEIGHT), .CRD_W(RW)) u_map_y (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_col        (s_axis_tdata[7:0]),
        .i_row        (s_axis_tdata[15:8]),
        .i_coef_col   (r_coef[REG_Y_COL]),
        .i_coef_row   (r_coef[REG_Y_ROW]),
        .i_coef_cross (r_coef[REG_Y_CROSS]),
        .i_coef_off   (r_coef[REG_Y_OFFSET]),
        .o_inside     (y_inside),
        .o_coord      (sy)
    );

    // source store: one access, write or read, per S4 load, in stream order
    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [AW-1:0]       mem_addr;
    logic [SAMPLE_W-1:0] r4_word;
    logic                r4_inside;
    logic                r4_band_ok;

    assign mem_addr = (r3_cmd == CMD_WRITE) ? r3_wr_addr : {r3_band, sy, sx};

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            if (r3_v && (r3_cmd == CMD_WRITE) && r3_wr_ok) begin
                mem[mem_addr] <= r3_sample;
            end
            r4_word <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_inside  <= x_inside && y_inside;
            r4_band_ok <= r3_band_ok;
        end
    end

    // output register; +0.0, -0.0 and outside or bad-band reads return zero
    logic [SAMPLE_W-1:0] r5_data;
    logic                r5_inside;

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_data   <= (r4_inside && r4_band_ok && (r4_word[30:0] != 31'd0)) ?
                         r4_word : '0;
            r5_inside <= r4_inside;
        end
    end

    assign m_axis_tvalid = r5_v;
    assign m_axis_tdata  = r5_data;
    assign m_axis_tuser  = r5_inside;

endmodule

// ===== sv/pwarp_map.sv =====
// ---------------------------------------------------------------------------
// pwarp_map
// Three-stage evaluation of one bilinear axis polynomial with inside test.
// ---------------------------------------------------------------------------
module pwarp_map #(
    parameter int LIMIT = 256,
    parameter int CRD_W = 8
) (
    input  logic                 i_clk,
    input  pwarp_pkg::t_stage_en i_en,
    input  logic [7:0]           i_col,
    input  logic [7:0]           i_row,
    input  pwarp_pkg::t_coef     i_coef_col,
    input  pwarp_pkg::t_coef     i_coef_row,
    input  pwarp_pkg::t_coef     i_coef_cross,
    input  pwarp_pkg::t_coef     i_coef_off,
    output logic                 o_inside,
    output logic [CRD_W-1:0]     o_coord
);
    import pwarp_pkg::*;

    // stage 1: linear terms and col*row
    logic        [15:0] r_ij;
    logic signed [56:0] r_p_col;
    logic signed [56:0] r_p_row;
    // stage 2: linear sum and cross term
    logic signed [57:0] r_small;
    logic signed [64:0] r_cross;
    // stage 3: exact sum, truncated coordinate
    logic signed [65:0] sum;
    logic        [33:0] hi;
    logic               in_img;
    logic               r_inside;
    logic [CRD_W-1:0]   r_coord;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_ij    <= i_col * i_row;
            r_p_col <= $signed({1'b0, i_col}) * i_coef_col;
            r_p_row <= $signed({1'b0, i_row}) * i_coef_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_small <= 58'(r_p_col) + 58'(r_p_row) + 58'(i_coef_off);
            r_cross <= $signed({1'b0, r_ij}) * i_coef_cross;
        end
    end

    // never overflows at 66 bits, so the 64-bit saturation needs no logic:
    // a saturated sum is outside either way
    assign sum = 66'(r_small) + 66'(r_cross);
    assign hi  = sum[65:32];
    // inside when -1.0 < sum and floor(sum) < LIMIT
    assign in_img = (!hi[33] && (hi[32:0] < 33'(LIMIT))) ||
                    ((&hi) && (sum[31:0] != 32'd0));

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_inside <= in_img;
            r_coord  <= hi[33] ? '0 : hi[CRD_W-1:0];
        end
    end

    assign o_inside = r_inside;
    assign o_coord  = r_coord;

endmodule

// ===== sv/pwarp_checker.sv =====
// ---------------------------------------------------------------------------
// pwarp_checker
// Port-level checks of the image warp, bound to the top level.
// ---------------------------------------------------------------------------
module pwarp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a sample only comes back from inside the image, never as signed zero
    a_sample_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata == 32'd0) ||
            (m_axis_tuser && (m_axis_tdata != 32'h8000_0000)))
        else $error("sample from outside or signed zero");

    // an empty pipe takes a transfer straight after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("not ready after reset");

endmodule

bind polynomial_image_warp_top pwarp_checker u_pwarp_checker (.*);
